/* sv/afps_pkg.sv */
// ----------------------------------------------------------------------------
// afps_pkg
// Shared types and constants of the frame packet splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package afps_pkg;

	localparam int STAMP_W   = 48;
	localparam int COUNT_W   = 20;
	localparam int WORD_W    = 32;
	localparam int CFG_W     = 8;
	localparam int TC_W      = 4;
	localparam int STEREO_W  = 8;

	localparam logic [31:0] WORD_BYTES = 32'd4;

	// configuration register indexes
	localparam logic CFG_TRACK_COUNT = 1'b0;
	localparam logic CFG_STEREO_MASK = 1'b1;

	// input function codes
	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_SEEK = 1'b1;

	typedef enum logic [1:0] {
		KIND_AUDIO = 2'd0,
		KIND_VIDEO = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SIZE    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_VIDEO   = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t               kind;
		logic [3:0]          stream_id;
		logic [STAMP_W-1:0]  pts;
		logic [WORD_W-1:0]   offset;
		logic [WORD_W-1:0]   length;
		logic                key;
		logic                last;
	} result_t;

	function automatic result_t make_result(kind_t k, logic [3:0] s,
			logic [STAMP_W-1:0] p, logic [WORD_W-1:0] o, logic [WORD_W-1:0] l,
			logic ky);
		result_t r;
		r.kind      = k;
		r.stream_id = s;
		r.pts       = p;
		r.offset    = o;
		r.length    = l;
		r.key       = ky;
		r.last      = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/afps_ram.sv */
// ----------------------------------------------------------------------------
// afps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module afps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/afps_stamp_store.sv */
// ----------------------------------------------------------------------------
// afps_stamp_store
// Audio timestamp memory with per-track valid flags; clear zeroes all tracks.
// ----------------------------------------------------------------------------
`default_nettype none

module afps_stamp_store
	import afps_pkg::*;
#(
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [AW-1:0]      rd_addr,
	output logic      [STAMP_W-1:0] rd_data,
	input  wire logic               we,
	input  wire logic [AW-1:0]      wr_addr,
	input  wire logic [STAMP_W-1:0] wr_data,
	input  wire logic               clear
);

	logic [DEPTH-1:0]   valid_q;
	logic [AW-1:0]      rd_addr_s1;
	logic [STAMP_W-1:0] ram_rdata;

	afps_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_addr_s1 <= '0;
		end else begin
			rd_addr_s1 <= rd_addr;
			if (clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// entries not written since reset or the last seek read as zero
	assign rd_data = valid_q[rd_addr_s1] ? ram_rdata : '0;

endmodule

`default_nettype wire

/* sv/afps_core.sv */
// ----------------------------------------------------------------------------
// afps_core
// Frame byte parser: size words, chunk payloads, video tail and errors.
// ----------------------------------------------------------------------------
`default_nettype none

module afps_core
	import afps_pkg::*;
#(
	parameter int MAX_TRACKS = 8,
	localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               func,
	input  wire logic [7:0]         data_byte,
	input  wire logic               frame_start,
	input  wire logic [31:0]        frame_size,
	input  wire logic               key_in,
	input  wire logic [19:0]        seek_target,
	input  wire logic               write_en,
	input  wire logic               reg_index,
	input  wire logic [CFG_W-1:0]   write_data,
	output logic      [AW-1:0]      stamp_rd_addr,
	input  wire logic [STAMP_W-1:0] stamp_rdata,
	output logic                    stamp_we,
	output logic      [AW-1:0]      stamp_waddr,
	output logic      [STAMP_W-1:0] stamp_wdata,
	output logic                    stamp_clear,
	output logic                    res_valid,
	output result_t                 res
);

	localparam int TW = $clog2(MAX_TRACKS + 1);
	localparam int CW = (TW > TC_W) ? TW : TC_W;

	phase_t              ph_q, ph_d;
	logic [TW-1:0]       track_now_q, tn_d;
	logic [31:0]         byte_pos_q, bp_d;
	logic [31:0]         bytes_left_q, bl_d;
	logic [31:0]         chunk_left_q, cl_d;
	logic [31:0]         word_q, wg_d;
	logic [2:0]          gather_q, gn_d;
	logic                frame_key_q, fk_d;
	logic [COUNT_W-1:0]  video_cnt_q, vc_d;
	logic [TC_W-1:0]     track_count_q, tc_d;
	logic [STEREO_W-1:0] stereo_mask_q, sm_d;

	logic [CW-1:0]       used;
	logic [AW+2:0]       pay_track;
	logic                stereo;

	assign used = (CW'(track_count_q) > CW'(MAX_TRACKS)) ? CW'(MAX_TRACKS)
		: CW'(track_count_q);

	// size word reads the current track, payload the one just sized
	assign stamp_rd_addr = (ph_q == PH_PAYLOAD) ? AW'(track_now_q - TW'(1))
		: AW'(track_now_q);

	assign pay_track = (AW + 3)'(AW'(track_now_q - TW'(1)));
	assign stereo    = (pay_track < (AW + 3)'(8)) && stereo_mask_q[pay_track[2:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q          <= PH_IDLE;
			track_now_q   <= '0;
			byte_pos_q    <= '0;
			bytes_left_q  <= '0;
			chunk_left_q  <= '0;
			word_q        <= '0;
			gather_q      <= '0;
			frame_key_q   <= 1'b0;
			video_cnt_q   <= '0;
			track_count_q <= '0;
			stereo_mask_q <= '0;
		end else begin
			ph_q          <= ph_d;
			track_now_q   <= tn_d;
			byte_pos_q    <= bp_d;
			bytes_left_q  <= bl_d;
			chunk_left_q  <= cl_d;
			word_q        <= wg_d;
			gather_q      <= gn_d;
			frame_key_q   <= fk_d;
			video_cnt_q   <= vc_d;
			track_count_q <= tc_d;
			stereo_mask_q <= sm_d;
		end
	end

	always_comb begin
		logic [31:0]   size_w;
		logic [TW-1:0] t_cur;
		logic [31:0]   inc;

		ph_d = ph_q;
		tn_d = track_now_q;
		bp_d = byte_pos_q;
		bl_d = bytes_left_q;
		cl_d = chunk_left_q;
		wg_d = word_q;
		gn_d = gather_q;
		fk_d = frame_key_q;
		vc_d = video_cnt_q;
		tc_d = track_count_q;
		sm_d = stereo_mask_q;
		res_valid   = 1'b0;
		res         = '0;
		stamp_we    = 1'b0;
		stamp_waddr = AW'(track_now_q - TW'(1));
		stamp_wdata = '0;
		stamp_clear = 1'b0;
		size_w      = '0;
		t_cur       = '0;
		inc         = stereo ? (word_q >> 2) : (word_q >> 1);

		if (write_en) begin
			case (reg_index)
				CFG_TRACK_COUNT: tc_d = write_data[TC_W-1:0];
				CFG_STEREO_MASK: sm_d = write_data[STEREO_W-1:0];
				default: ;
			endcase
		end

		if (accept) begin
			if (func == FUNC_SEEK) begin
				vc_d        = seek_target;
				stamp_clear = 1'b1;
				ph_d        = PH_IDLE;
				tn_d        = '0;
			end else begin
				if (frame_start) begin
					bl_d = frame_size;
					bp_d = '0;
					tn_d = '0;
					cl_d = '0;
					fk_d = key_in;
					if (CW'(tn_d) >= used) begin
						res_valid = 1'b1;
						res  = make_result(KIND_VIDEO, 4'd0, STAMP_W'(vc_d), bp_d, bl_d, fk_d);
						vc_d = vc_d + COUNT_W'(1);
						ph_d = PH_VIDEO;
					end else if (bl_d < WORD_BYTES) begin
						res_valid = 1'b1;
						res  = make_result(KIND_ERROR, 4'((TW + 1)'(tn_d) + (TW + 1)'(1)),
							STAMP_W'(vc_d), bp_d, bl_d, fk_d);
						ph_d = PH_IDLE;
					end else begin
						ph_d = PH_SIZE;
						wg_d = '0;
						gn_d = '0;
					end
				end

				if (ph_d == PH_SIZE) begin
					case (gn_d[1:0])
						2'd0: wg_d[7:0]   = wg_d[7:0] | data_byte;
						2'd1: wg_d[15:8]  = wg_d[15:8] | data_byte;
						2'd2: wg_d[23:16] = wg_d[23:16] | data_byte;
						default: wg_d[31:24] = wg_d[31:24] | data_byte;
					endcase
					gn_d = gn_d + 3'd1;
					bp_d = bp_d + 32'd1;
					bl_d = bl_d - 32'd1;
					if (gn_d == 3'd4) begin
						size_w = wg_d;
						if (size_w > bl_d) begin
							res_valid = 1'b1;
							res  = make_result(KIND_ERROR, 4'((TW + 1)'(tn_d) + (TW + 1)'(1)),
								STAMP_W'(vc_d), bp_d, bl_d, fk_d);
							ph_d = PH_IDLE;
						end else begin
							bl_d  = bl_d - size_w;
							cl_d  = size_w;
							t_cur = tn_d;
							tn_d  = tn_d + TW'(1);
							wg_d  = '0;
							if (size_w == 32'd0) begin
								// empty chunk: straight on to the next part
								if (CW'(tn_d) >= used) begin
									res_valid = 1'b1;
									res  = make_result(KIND_VIDEO, 4'd0, STAMP_W'(vc_d),
										bp_d, bl_d, fk_d);
									vc_d = vc_d + COUNT_W'(1);
									ph_d = PH_VIDEO;
								end else if (bl_d < WORD_BYTES) begin
									res_valid = 1'b1;
									res  = make_result(KIND_ERROR,
										4'((TW + 1)'(tn_d) + (TW + 1)'(1)),
										STAMP_W'(vc_d), bp_d, bl_d, fk_d);
									ph_d = PH_IDLE;
								end else begin
									ph_d = PH_SIZE;
									gn_d = '0;
								end
							end else begin
								ph_d = PH_PAYLOAD;
								if (size_w < WORD_BYTES) begin
									// too short for a data word: payload is skipped
									gn_d = 3'd4;
								end else begin
									gn_d = '0;
									res_valid = 1'b1;
									res = make_result(KIND_AUDIO,
										4'((TW + 1)'(t_cur) + (TW + 1)'(1)),
										stamp_rdata, bp_d, size_w, 1'b0);
								end
							end
						end
					end
				end else if (ph_d == PH_PAYLOAD) begin
					bp_d = bp_d + 32'd1;
					cl_d = cl_d - 32'd1;
					if (!gn_d[2]) begin
						case (gn_d[1:0])
							2'd0: wg_d[7:0]   = wg_d[7:0] | data_byte;
							2'd1: wg_d[15:8]  = wg_d[15:8] | data_byte;
							2'd2: wg_d[23:16] = wg_d[23:16] | data_byte;
							default: wg_d[31:24] = wg_d[31:24] | data_byte;
						endcase
						gn_d = gn_d + 3'd1;
						if (gn_d == 3'd4) begin
							inc         = stereo ? (wg_d >> 2) : (wg_d >> 1);
							stamp_we    = 1'b1;
							stamp_wdata = stamp_rdata + STAMP_W'(inc);
						end
					end
					if (cl_d == 32'd0) begin
						if (CW'(tn_d) >= used) begin
							res_valid = 1'b1;
							res  = make_result(KIND_VIDEO, 4'd0, STAMP_W'(vc_d),
								bp_d, bl_d, fk_d);
							vc_d = vc_d + COUNT_W'(1);
							ph_d = PH_VIDEO;
						end else if (bl_d < WORD_BYTES) begin
							res_valid = 1'b1;
							res  = make_result(KIND_ERROR,
								4'((TW + 1)'(tn_d) + (TW + 1)'(1)),
								STAMP_W'(vc_d), bp_d, bl_d, fk_d);
							ph_d = PH_IDLE;
						end else begin
							ph_d = PH_SIZE;
							wg_d = '0;
							gn_d = '0;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/av_frame_packet_splitter_unit.sv */
// ----------------------------------------------------------------------------
// av_frame_packet_splitter_unit
// Splits media frame bytes into audio, video and error packet descriptors.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  input     func data_byte frame_start frame_size     in_valid / in_ready
//            key_in seek_target
//  output    kind stream_id pts offset length          out_valid / out_ready
//            key last
//  config    reg_index write_data                      write_en, no wait
//
//  One byte per cycle while in_ready holds; at most one registered result per byte.
//  Audio timestamps live in a RAM read each cycle at the active track, so a
//  stamp is ready well before a size word or data word completes.
//  A seek clears per-track valid flags at once: no clearing pass after reset.
//  in_ready drops only while a held result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module av_frame_packet_splitter_unit
	import afps_pkg::*;
#(
	parameter int MAX_TRACKS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [7:0]         data_byte,
	input  wire logic               frame_start,
	input  wire logic [31:0]        frame_size,
	input  wire logic               key_in,
	input  wire logic [19:0]        seek_target,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [1:0]         kind,
	output logic      [3:0]         stream_id,
	output logic      [STAMP_W-1:0] pts,
	output logic      [31:0]        offset,
	output logic      [31:0]        length,
	output logic                    key,
	output logic                    last,
	input  wire logic               write_en,
	input  wire logic               reg_index,
	input  wire logic [CFG_W-1:0]   write_data
);

	localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	logic               accept;
	logic [AW-1:0]      stamp_rd_addr;
	logic [STAMP_W-1:0] stamp_rdata;
	logic               stamp_we;
	logic [AW-1:0]      stamp_waddr;
	logic [STAMP_W-1:0] stamp_wdata;
	logic               stamp_clear;
	logic               res_valid;
	result_t            res;
	logic               out_valid_q;
	result_t            out_res_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	afps_stamp_store #(
		.DEPTH(MAX_TRACKS)
	) u_stamps (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(stamp_rd_addr),
		.rd_data(stamp_rdata),
		.we     (stamp_we),
		.wr_addr(stamp_waddr),
		.wr_data(stamp_wdata),
		.clear  (stamp_clear)
	);

	afps_core #(
		.MAX_TRACKS(MAX_TRACKS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.frame_size   (frame_size),
		.key_in       (key_in),
		.seek_target  (seek_target),
		.write_en     (write_en),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.stamp_rd_addr(stamp_rd_addr),
		.stamp_rdata  (stamp_rdata),
		.stamp_we     (stamp_we),
		.stamp_waddr  (stamp_waddr),
		.stamp_wdata  (stamp_wdata),
		.stamp_clear  (stamp_clear),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_res_q.kind;
	assign stream_id = out_res_q.stream_id;
	assign pts       = out_res_q.pts;
	assign offset    = out_res_q.offset;
	assign length    = out_res_q.length;
	assign key       = out_res_q.key;
	assign last      = out_res_q.last;

	// a result is only formed for an accepted transaction
	a_res_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> accept)
		else $error("result formed without an accepted transaction");

	// stamp updates come from data bytes, never alongside a seek clear
	a_stamp_write: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_we |-> (accept && !stamp_clear))
		else $error("stamp write outside a data transaction");

	// a seek yields no result, and the output slot was free or drained
	a_seek_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_SEEK) |=> !out_valid)
		else $error("output valid after a seek");

endmodule

`default_nettype wire

/* tb/sv/afps_checker.sv */
// ----------------------------------------------------------------------------
// afps_checker
// Watches the splitter's input, output and register ports, predicts every
// packet descriptor from the accepted frame bytes and compares it, field by
// field, with what the unit delivers.
// ----------------------------------------------------------------------------
module afps_checker
	import afps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               func,
	input  wire logic [7:0]         data_byte,
	input  wire logic               frame_start,
	input  wire logic [31:0]        frame_size,
	input  wire logic               key_in,
	input  wire logic [19:0]        seek_target,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [3:0]         stream_id,
	input  wire logic [STAMP_W-1:0] pts,
	input  wire logic [31:0]        offset,
	input  wire logic [31:0]        length,
	input  wire logic               key,
	input  wire logic               last,
	input  wire logic               write_en,
	input  wire logic               reg_index,
	input  wire logic [CFG_W-1:0]   write_data,
	output int                      fail_count,
	output int                      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TRACKS = 8;

	logic [TC_W-1:0]     cfg_tracks;
	logic [STEREO_W-1:0] cfg_stereo;
	logic [COUNT_W-1:0]  vid_count;
	logic [STAMP_W-1:0]  stamp [NUM_TRACKS];
	logic [3:0]          trk;
	phase_t              ph;
	logic [WORD_W-1:0]   pos;
	logic [WORD_W-1:0]   remain;
	logic [WORD_W-1:0]   chunk_rem;
	logic [WORD_W-1:0]   word_acc;
	int unsigned         got;
	logic                fkey;
	result_t             due_pkts [$];
	int                  mismatches = 0;
	int                  waiting = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting;

	function automatic logic [3:0] tracks_in_use();
		return (cfg_tracks > NUM_TRACKS) ? 4'(NUM_TRACKS) : cfg_tracks;
	endfunction

	task automatic push_pkt(input kind_t k, input logic [3:0] s,
			input logic [STAMP_W-1:0] p, input logic [WORD_W-1:0] o,
			input logic [WORD_W-1:0] l, input logic ky);
		result_t r;
		r.kind      = k;
		r.stream_id = s;
		r.pts       = p;
		r.offset    = o;
		r.length    = l;
		r.key       = ky;
		r.last      = 1'b1;
		due_pkts.push_back(r);
	endtask

	// rest of the frame is dropped until the next frame start or seek
	task automatic frame_fault();
		ph = PH_IDLE;
		push_pkt(KIND_ERROR, trk + 4'd1, STAMP_W'(vid_count), pos, remain, fkey);
	endtask

	task automatic open_next_part();
		if (trk >= tracks_in_use()) begin
			push_pkt(KIND_VIDEO, 4'd0, STAMP_W'(vid_count), pos, remain, fkey);
			vid_count = vid_count + 1'b1;
			ph = PH_VIDEO;
		end else if (remain < WORD_BYTES) begin
			frame_fault();
		end else begin
			ph = PH_SIZE;
			word_acc = '0;
			got = 0;
		end
	endtask

	task automatic take_size_byte(input logic [7:0] b);
		logic [WORD_W-1:0] chunk;
		logic [3:0]        t;
		word_acc = word_acc | (WORD_W'(b) << (8 * got));
		got++;
		pos++;
		remain--;
		if (got < WORD_BYTES)
			return;
		chunk = word_acc;
		if (chunk > remain) begin
			frame_fault();
			return;
		end
		remain    = remain - chunk;
		chunk_rem = chunk;
		t         = trk;
		trk++;
		word_acc  = '0;
		if (chunk == 0) begin
			open_next_part();
			return;
		end
		ph = PH_PAYLOAD;
		// chunks shorter than a word carry no timestamp word
		if (chunk < WORD_BYTES) begin
			got = WORD_BYTES;
			return;
		end
		got = 0;
		push_pkt(KIND_AUDIO, t + 4'd1, stamp[t[2:0]], pos, chunk, 1'b0);
	endtask

	task automatic take_payload_byte(input logic [7:0] b);
		logic [2:0] t;
		pos++;
		chunk_rem--;
		if (got < WORD_BYTES) begin
			word_acc = word_acc | (WORD_W'(b) << (8 * got));
			got++;
			if (got == WORD_BYTES) begin
				t = 3'(trk - 4'd1);
				stamp[t] = stamp[t] +
					STAMP_W'(word_acc / (cfg_stereo[t] ? 32'd4 : 32'd2));
			end
		end
		if (chunk_rem == 0)
			open_next_part();
	endtask

	task automatic split_item(input logic f, input logic [7:0] b, input logic fs,
			input logic [31:0] sz, input logic k, input logic [19:0] tgt);
		int queued_prior;
		if (f == FUNC_SEEK) begin
			vid_count = tgt;
			foreach (stamp[i])
				stamp[i] = '0;
			ph  = PH_IDLE;
			trk = '0;
			return;
		end
		if (fs) begin
			remain       = sz;
			pos          = '0;
			trk          = '0;
			chunk_rem    = '0;
			fkey         = k;
			queued_prior = due_pkts.size();
			open_next_part();
			if (due_pkts.size() != queued_prior)
				return;
		end
		case (ph)
			PH_SIZE:    take_size_byte(b);
			PH_PAYLOAD: take_payload_byte(b);
			default:    ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
			input logic [STAMP_W-1:0] seen);
		if (want !== seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg_tracks = '0;
			cfg_stereo = '0;
			vid_count  = '0;
			foreach (stamp[i])
				stamp[i] = '0;
			trk        = '0;
			ph         = PH_IDLE;
			pos        = '0;
			remain     = '0;
			chunk_rem  = '0;
			word_acc   = '0;
			got        = 0;
			fkey       = 1'b0;
			due_pkts.delete();
		end else begin
			// output side first, so a descriptor can never match its own byte
			if (out_valid && out_ready) begin
				if (due_pkts.size() == 0) begin
					$error("unexpected descriptor: kind %0d stream %0d", kind, stream_id);
					mismatches++;
				end else begin
					want = due_pkts.pop_front();
					check_field("kind", STAMP_W'(want.kind), STAMP_W'(kind));
					check_field("stream_id", STAMP_W'(want.stream_id),
						STAMP_W'(stream_id));
					check_field("pts", want.pts, pts);
					check_field("offset", STAMP_W'(want.offset), STAMP_W'(offset));
					check_field("length", STAMP_W'(want.length), STAMP_W'(length));
					check_field("key", STAMP_W'(want.key), STAMP_W'(key));
					check_field("last", STAMP_W'(want.last), STAMP_W'(last));
				end
			end
			if (write_en) begin
				case (reg_index)
					CFG_TRACK_COUNT: cfg_tracks = write_data[TC_W-1:0];
					CFG_STEREO_MASK: cfg_stereo = write_data[STEREO_W-1:0];
					default:         ;
				endcase
			end
			if (in_valid && in_ready)
				split_item(func, data_byte, frame_start, frame_size, key_in, seek_target);
		end
		waiting = due_pkts.size();
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Frame packet splitter testbench: directed frames for the corner cases, then
// random well-formed and broken frames, seeks and stray bytes under several
// settings and idle patterns; afps_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb
	import afps_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int LONG_HOLD       = 600;
	localparam int DRAIN_CYCLES    = 4;

	typedef enum int {
		FLAW_NONE,
		FLAW_SHORT,
		FLAW_HUGE_SIZE,
		FLAW_HUGE_CHUNK,
		FLAW_CUT
	} flaw_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic [7:0]         data_byte;
	logic               frame_start;
	logic [31:0]        frame_size;
	logic               key_in;
	logic [19:0]        seek_target;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic [3:0]         stream_id;
	logic [STAMP_W-1:0] pts;
	logic [31:0]        offset;
	logic [31:0]        length;
	logic               key;
	logic               last;
	logic               write_en;
	logic               reg_index;
	logic [CFG_W-1:0]   write_data;
	int                 fail_count;
	int                 outstanding;

	int   idle_pct   = 0;
	int   stall_pct  = 0;
	logic hold_req   = 1'b0;
	logic hold_seen  = 1'b0;
	int   hold_left  = 0;
	int   cycles     = 0;
	int   items_sent = 0;
	int   tracks_now = 0;

	av_frame_packet_splitter_unit u_top (.*);

	afps_checker u_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[av_frame_packet_splitter_unit] ERROR");
			$finish;
		end
	end

	// one input transaction; returns at the edge where it was accepted
	task automatic send_item(input logic f, input logic [7:0] b, input logic fs,
			input logic [31:0] sz, input logic k, input logic [19:0] tgt);
		logic taken;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid    <= 1'b1;
		func        <= f;
		data_byte   <= b;
		frame_start <= fs;
		frame_size  <= sz;
		key_in      <= k;
		seek_target <= tgt;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_bytes(input logic [7:0] fb[$], input logic [31:0] sz,
			input logic k);
		foreach (fb[i]) begin
			if (i == 0)
				send_item(FUNC_DATA, fb[i], 1'b1, sz, k, 20'($urandom()));
			else
				send_item(FUNC_DATA, fb[i], 1'b0, $urandom(), 1'($urandom()),
					20'($urandom()));
			items_sent++;
		end
	endtask

	// data fields ride along at random; a seek ignores them
	task automatic send_seek(input logic [19:0] tgt);
		send_item(FUNC_SEEK, 8'($urandom()), 1'($urandom()), $urandom(),
			1'($urandom()), tgt);
		items_sent++;
	endtask

	task automatic send_noise(input int n);
		repeat (n)
			send_item(FUNC_DATA, 8'($urandom()), 1'b0, $urandom(), 1'($urandom()),
				20'($urandom()));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		wait_drained();
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= val;
		@(posedge clk);
		write_en   <= 1'b0;
	endtask

	task automatic set_config(input logic [TC_W-1:0] tc, input logic [STEREO_W-1:0] sm);
		write_reg(CFG_TRACK_COUNT, CFG_W'(tc));
		write_reg(CFG_STEREO_MASK, CFG_W'(sm));
		tracks_now = (tc > 8) ? 8 : tc;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0:       begin idle_pct = 0;  stall_pct <= 0;  end
			1:       begin idle_pct = 78; stall_pct <= 0;  end
			2:       begin idle_pct = 0;  stall_pct <= 78; end
			default: begin idle_pct = 33; stall_pct <= 33; end
		endcase
	endtask

	task automatic send_frame(input flaw_t flaw);
		logic [7:0]  fb[$];
		logic [31:0] chunk;
		logic [31:0] sz;
		int          bad_track;
		int          pick;
		bad_track = (tracks_now > 0) ? $urandom_range(tracks_now - 1) : 0;
		for (int t = 0; t < tracks_now; t++) begin
			pick = $urandom_range(99);
			if (pick < 12)
				chunk = $urandom_range(3);
			else if (pick < 90)
				chunk = $urandom_range(4, 12);
			else
				chunk = $urandom_range(13, 40);
			if (flaw == FLAW_HUGE_CHUNK && t == bad_track)
				chunk = $urandom() | 32'h0000_1000;
			for (int i = 0; i < 4; i++)
				fb.push_back(chunk[8*i +: 8]);
			if (chunk > 40)
				chunk = 2;
			repeat (chunk)
				fb.push_back(8'($urandom()));
		end
		repeat ($urandom_range(8))
			fb.push_back(8'($urandom()));
		if (fb.size() == 0)
			fb.push_back(8'($urandom()));
		sz = fb.size();
		case (flaw)
			FLAW_SHORT:     sz = $urandom_range(fb.size() - 1);
			FLAW_HUGE_SIZE: sz = $urandom() | 32'h8000_0000;
			FLAW_CUT:       repeat ($urandom_range(fb.size() - 1)) void'(fb.pop_back());
			default:        ;
		endcase
		send_bytes(fb, sz, 1'($urandom_range(1)));
	endtask

	initial begin
		logic [7:0] fb[$];
		logic       held;
		logic       paused;
		held        = 1'b0;
		paused      = 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_DATA;
		data_byte   <= '0;
		frame_start <= 1'b0;
		frame_size  <= '0;
		key_in      <= 1'b0;
		seek_target <= '0;
		write_en    <= 1'b0;
		reg_index   <= CFG_TRACK_COUNT;
		write_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no tracks: video descriptor on the first byte, full-size frame
		fb = {8'h5A};
		send_bytes(fb, 32'hFFFF_FFFF, 1'b1);
		send_seek(20'hFFFFF);
		// video counter wraps after this one
		fb = {8'hA5};
		send_bytes(fb, 32'd0, 1'b0);

		set_config(4'd1, 8'hFF);
		fb = {8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h11, 8'h22};
		send_bytes(fb, 32'd10, 1'b1);
		// remainder under a size word at the first track
		fb = {8'h01, 8'h02, 8'h03};
		send_bytes(fb, 32'd3, 1'b0);
		// chunk larger than what is left of the frame
		fb = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_bytes(fb, 32'd8, 1'b1);

		set_config(4'd1, 8'h00);
		// short chunk skipped, video follows with nothing left
		fb = {8'h02, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB};
		send_bytes(fb, 32'd6, 1'b0);

		for (int p = 0; p < 8; p++) begin
			int goal;
			int pick;
			set_idling(p % 4);
			case (p)
				0:       set_config(4'd1, 8'h00);
				1:       set_config(4'd8, 8'hFF);
				2:       set_config(4'd15, 8'hA5);
				3:       set_config(4'd0, 8'($urandom()));
				4:       set_config(4'd3, 8'($urandom()));
				5:       set_config(4'd8, 8'h00);
				6:       set_config(4'd2, 8'hFF);
				default: set_config(4'($urandom_range(15)), 8'($urandom()));
			endcase
			goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) begin
				// receiver goes quiet while bytes keep coming
				if (p == 0 && !held && goal - items_sent < 120) begin
					hold_req <= ~hold_req;
					held = 1'b1;
				end
				if (p == 2 && !paused && goal - items_sent < 100) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 68)
					send_frame(FLAW_NONE);
				else if (pick < 86)
					send_frame(flaw_t'($urandom_range(FLAW_SHORT, FLAW_CUT)));
				else if (pick < 93)
					send_seek(($urandom_range(9) == 0) ? 20'hFFFFF : 20'($urandom()));
				else
					send_noise($urandom_range(1, 4));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("[av_frame_packet_splitter_unit] OK");
		else
			$display("[av_frame_packet_splitter_unit] ERROR");
		$finish;
	end

endmodule
